// ===== rtl/oriented_rectangle_corners_top_defines.svh =====
// Assertion macros for the oriented rectangle corners block.
`ifndef ORIENTED_RECTANGLE_CORNERS_TOP_DEFINES_SVH
`define ORIENTED_RECTANGLE_CORNERS_TOP_DEFINES_SVH

// Assert that an implication holds on every clock edge outside reset.
`define ORC_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error(msg);

// Assert that an implication's consequent holds at the next clock edge.
`define ORC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error(msg);

`endif

// ===== rtl/orc_pkg.sv =====
package orc_pkg;
	localparam int unsigned DimW  = 31;
	localparam int unsigned PosW  = 32;
	localparam int unsigned DirW  = 16;
	localparam int unsigned TrigW = 16;
	localparam int unsigned SqW   = 33;
	localparam int unsigned QW    = 32;
	localparam int unsigned RootW = 16;
	localparam int unsigned ProdW = 48;
	localparam logic [TrigW-1:0] CosOne = 16'sd32767;
	localparam logic [RootW-1:0] MagMax = 16'd32767;
	localparam logic [1:0] CornerLast = 2'd3;
	localparam int unsigned InTdataW  = 160;
	localparam int unsigned OutTdataW = 72;

	typedef struct packed {
		logic [DimW-1:0]        w;
		logic [DimW-1:0]        h;
		logic signed [PosW-1:0] cx;
		logic signed [PosW-1:0] cy;
	} rect_t;
endpackage

// ===== rtl/oriented_rectangle_corners_top.sv =====
// Oriented rectangle corners. A request on the slave stream carries a rectangle (width,
// height, centre in Q16.16) and a direction vector of any scale; the master stream gives
// the four rotated corners (-w/2,-h/2), (+w/2,-h/2), (+w/2,+h/2), (-w/2,+h/2), one per
// beat, with tlast on the fourth. The direction is normalised into Q1.15 cosine and sine
// by a pipelined divider (one quotient bit a stage, 31 stages) and a pipelined square root
// (one root bit a stage, 16 stages). The first corner of a request passes through the norm,
// divider, root, head, product and output registers in that order, and the other three
// follow it. The corner emitter gives one corner per cycle while the output does not stall
// and holds the whole front pipeline while it works through a rectangle, so a new request
// is taken only as the last corner of the previous one enters the product stage; requests
// are taken every cycle while the emitter has nothing to work on. Corners saturate to the
// signed 32-bit range.
`include "oriented_rectangle_corners_top_defines.svh"
module oriented_rectangle_corners_top
	import orc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// tdata: rect_width[30:0], rect_height[61:31], center_x[93:62], center_y[125:94],
	// dir_x[141:126], dir_y[157:142], zero fill
	input  logic [InTdataW-1:0]  s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// tdata: corner_index[1:0], corner_x[33:2], corner_y[65:34], zero fill
	output logic [OutTdataW-1:0] m_tdata,
	output logic                 m_tlast
);
	// Stage counts: one divider stage per quotient bit, one root stage per root bit.
	localparam int unsigned DivN = QW - 1;
	localparam int unsigned SqrN = RootW;

	// Pipeline advances when the head register is empty or the emitter takes the head item's last corner.
	logic adv;

	// Stage 1: squares and norm.
	logic               v_s1;
	rect_t              r_s1;
	logic               zero_s1;
	logic               nx_s1, ny_s1;
	logic [SqW-1:0]     n_s1;
	logic [SqW-2:0]     ax2_s1, ay2_s1;

	logic signed [DirW-1:0] dx_in, dy_in;
	logic [DirW:0] ax_in, ay_in;
	assign dx_in = s_tdata[141:126];
	assign dy_in = s_tdata[157:142];
	assign ax_in = dx_in[DirW-1] ? (DirW+1)'(-{dx_in[DirW-1], dx_in}) : {1'b0, dx_in};
	assign ay_in = dy_in[DirW-1] ? (DirW+1)'(-{dy_in[DirW-1], dy_in}) : {1'b0, dy_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1.w  <= s_tdata[30:0];
			r_s1.h  <= s_tdata[61:31];
			r_s1.cx <= s_tdata[93:62];
			r_s1.cy <= s_tdata[125:94];
			nx_s1   <= dx_in[DirW-1];
			ny_s1   <= dy_in[DirW-1];
			ax2_s1  <= (SqW-1)'(ax_in) * (SqW-1)'(ax_in);
			ay2_s1  <= (SqW-1)'(ay_in) * (SqW-1)'(ay_in);
			n_s1    <= SqW'(ax_in) * SqW'(ax_in) + SqW'(ay_in) * SqW'(ay_in);
			zero_s1 <= (dx_in == '0) && (dy_in == '0);
		end
	end

	// Divider: restoring, two lanes (x and y), numerator a^2 * 2^30, one bit a stage.
	// The quotient never exceeds 2^30, so the numerator above its low 31 bits (a^2 >> 1,
	// always below the norm) preloads the remainder and the low 31 bits enter one a stage.
	logic               dv_v   [DivN+1];
	rect_t              dv_r   [DivN+1];
	logic               dv_z   [DivN+1];
	logic               dv_nx  [DivN+1];
	logic               dv_ny  [DivN+1];
	logic [SqW-1:0]     dv_n   [DivN+1];
	logic [QW-1:0]      dv_numx[DivN+1];
	logic [QW-1:0]      dv_numy[DivN+1];
	logic [SqW:0]       dv_remx[DivN+1];
	logic [SqW:0]       dv_remy[DivN+1];
	logic [QW-1:0]      dv_qx  [DivN+1];
	logic [QW-1:0]      dv_qy  [DivN+1];

	assign dv_v[0]    = v_s1;
	assign dv_r[0]    = r_s1;
	assign dv_z[0]    = zero_s1;
	assign dv_nx[0]   = nx_s1;
	assign dv_ny[0]   = ny_s1;
	assign dv_n[0]    = zero_s1 ? SqW'(1) : n_s1;
	assign dv_numx[0] = {ax2_s1[0], (QW-1)'(0)};
	assign dv_numy[0] = {ay2_s1[0], (QW-1)'(0)};
	assign dv_remx[0] = (SqW+1)'(ax2_s1[SqW-2:1]);
	assign dv_remy[0] = (SqW+1)'(ay2_s1[SqW-2:1]);
	assign dv_qx[0]   = '0;
	assign dv_qy[0]   = '0;

	for (genvar i = 0; i < DivN; i++) begin : g_div
		logic [SqW:0] tx, ty;
		assign tx = {dv_remx[i][SqW-1:0], dv_numx[i][QW-1]};
		assign ty = {dv_remy[i][SqW-1:0], dv_numy[i][QW-1]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[i+1] <= 1'b0;
			end else if (adv) begin
				dv_v[i+1] <= dv_v[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_r[i+1]    <= dv_r[i];
				dv_z[i+1]    <= dv_z[i];
				dv_nx[i+1]   <= dv_nx[i];
				dv_ny[i+1]   <= dv_ny[i];
				dv_n[i+1]    <= dv_n[i];
				dv_numx[i+1] <= dv_numx[i] << 1;
				dv_numy[i+1] <= dv_numy[i] << 1;
				if (tx >= {1'b0, dv_n[i]}) begin
					dv_remx[i+1] <= tx - {1'b0, dv_n[i]};
					dv_qx[i+1]   <= {dv_qx[i][QW-2:0], 1'b1};
				end else begin
					dv_remx[i+1] <= tx;
					dv_qx[i+1]   <= {dv_qx[i][QW-2:0], 1'b0};
				end
				if (ty >= {1'b0, dv_n[i]}) begin
					dv_remy[i+1] <= ty - {1'b0, dv_n[i]};
					dv_qy[i+1]   <= {dv_qy[i][QW-2:0], 1'b1};
				end else begin
					dv_remy[i+1] <= ty;
					dv_qy[i+1]   <= {dv_qy[i][QW-2:0], 1'b0};
				end
			end
		end
	end

	// Square root: digit by digit, one root bit a stage, two lanes.
	logic               sq_v   [SqrN+1];
	rect_t              sq_r   [SqrN+1];
	logic               sq_z   [SqrN+1];
	logic               sq_nx  [SqrN+1];
	logic               sq_ny  [SqrN+1];
	logic [QW-1:0]      sq_vx  [SqrN+1];
	logic [QW-1:0]      sq_vy  [SqrN+1];
	logic [RootW-1:0]   sq_rx  [SqrN+1];
	logic [RootW-1:0]   sq_ry  [SqrN+1];
	logic [QW+1:0]      sq_ax  [SqrN+1];
	logic [QW+1:0]      sq_ay  [SqrN+1];

	assign sq_v[0]  = dv_v[DivN];
	assign sq_r[0]  = dv_r[DivN];
	assign sq_z[0]  = dv_z[DivN];
	assign sq_nx[0] = dv_nx[DivN];
	assign sq_ny[0] = dv_ny[DivN];
	assign sq_vx[0] = dv_qx[DivN];
	assign sq_vy[0] = dv_qy[DivN];
	assign sq_rx[0] = '0;
	assign sq_ry[0] = '0;
	assign sq_ax[0] = '0;
	assign sq_ay[0] = '0;

	for (genvar j = 0; j < SqrN; j++) begin : g_sqrt
		logic [QW+1:0] ax, ay, trx, try_;
		assign ax   = {sq_ax[j][QW-1:0], sq_vx[j][QW-1:QW-2]};
		assign ay   = {sq_ay[j][QW-1:0], sq_vy[j][QW-1:QW-2]};
		assign trx  = (QW+2)'({sq_rx[j], 2'b01});
		assign try_ = (QW+2)'({sq_ry[j], 2'b01});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[j+1] <= 1'b0;
			end else if (adv) begin
				sq_v[j+1] <= sq_v[j];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_r[j+1]  <= sq_r[j];
				sq_z[j+1]  <= sq_z[j];
				sq_nx[j+1] <= sq_nx[j];
				sq_ny[j+1] <= sq_ny[j];
				sq_vx[j+1] <= sq_vx[j] << 2;
				sq_vy[j+1] <= sq_vy[j] << 2;
				if (ax >= trx) begin
					sq_ax[j+1] <= ax - trx;
					sq_rx[j+1] <= {sq_rx[j][RootW-2:0], 1'b1};
				end else begin
					sq_ax[j+1] <= ax;
					sq_rx[j+1] <= {sq_rx[j][RootW-2:0], 1'b0};
				end
				if (ay >= try_) begin
					sq_ay[j+1] <= ay - try_;
					sq_ry[j+1] <= {sq_ry[j][RootW-2:0], 1'b1};
				end else begin
					sq_ay[j+1] <= ay;
					sq_ry[j+1] <= {sq_ry[j][RootW-2:0], 1'b0};
				end
			end
		end
	end

	// Head register: saturate magnitudes, apply signs, pick the zero-vector case.
	logic                    hv_q;
	rect_t                   hr_q;
	logic signed [TrigW-1:0] hc_q, hs_q;
	logic [RootW-1:0]        mx, my;
	logic signed [TrigW-1:0] cc, ss;
	assign mx = (sq_rx[SqrN] > MagMax) ? MagMax : sq_rx[SqrN];
	assign my = (sq_ry[SqrN] > MagMax) ? MagMax : sq_ry[SqrN];
	always_comb begin
		cc = sq_nx[SqrN] ? -TrigW'(mx) : TrigW'(mx);
		ss = sq_ny[SqrN] ? -TrigW'(my) : TrigW'(my);
		if (sq_z[SqrN]) begin
			cc = CosOne;
			ss = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= 1'b0;
		end else if (adv) begin
			hv_q <= sq_v[SqrN];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			hr_q <= sq_r[SqrN];
			hc_q <= cc;
			hs_q <= ss;
		end
	end

	// Corner emitter: four corners per item. Products registered, then sum/round/saturate.
	logic [1:0] k_q;
	logic       e_busy;
	logic       p_v_s1, p_v_s2;
	logic       p_stall;
	assign p_stall = p_v_s2 && m_tvalid && !m_tready;
	assign e_busy  = hv_q;
	// Head item leaves after its fourth corner enters the product stage.
	assign adv = !hv_q || ((k_q == CornerLast) && !p_stall);
	assign s_tready = adv;

	// Product stage.
	logic signed [ProdW-1:0] wc_s1, ws_s1, hc_s1, hs_s1;
	logic signed [PosW-1:0]  pcx_s1, pcy_s1;
	logic [1:0]              pk_s1;
	logic signed [DimW:0]    wsg, hsg;
	assign wsg = (k_q == 2'd1 || k_q == 2'd2) ? $signed({1'b0, hr_q.w})
		: -$signed({1'b0, hr_q.w});
	assign hsg = (k_q[1]) ? $signed({1'b0, hr_q.h}) : -$signed({1'b0, hr_q.h});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			p_v_s1 <= 1'b0;
		end else if (!p_stall) begin
			p_v_s1 <= e_busy;
			if (e_busy) k_q <= k_q + 2'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (!p_stall) begin
			wc_s1  <= ProdW'(wsg) * ProdW'(hc_q);
			ws_s1  <= ProdW'(wsg) * ProdW'(hs_q);
			hc_s1  <= ProdW'(hsg) * ProdW'(hc_q);
			hs_s1  <= ProdW'(hsg) * ProdW'(hs_q);
			pcx_s1 <= hr_q.cx;
			pcy_s1 <= hr_q.cy;
			pk_s1  <= k_q;
		end
	end

	// Output stage: px = wc - hs, py = ws + hc; round half up, add centre, saturate.
	logic signed [ProdW:0]   px, py;
	logic signed [ProdW:0]   rx, ry;
	logic signed [ProdW:0]   sx, sy;
	logic signed [PosW-1:0]  ox_s2, oy_s2;
	logic [1:0]              ok_s2;
	localparam logic signed [ProdW:0] SatHi = (ProdW+1)'(64'sh7FFFFFFF);
	localparam logic signed [ProdW:0] SatLo = -(ProdW+1)'(64'sh80000000);
	assign px = (ProdW+1)'(wc_s1) - (ProdW+1)'(hs_s1);
	assign py = (ProdW+1)'(ws_s1) + (ProdW+1)'(hc_s1);
	assign rx = (px + (ProdW+1)'(32768)) >>> 16;
	assign ry = (py + (ProdW+1)'(32768)) >>> 16;
	assign sx = rx + (ProdW+1)'(pcx_s1);
	assign sy = ry + (ProdW+1)'(pcy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_v_s2 <= 1'b0;
		end else if (!p_stall) begin
			p_v_s2 <= p_v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (!p_stall) begin
			ox_s2 <= (sx > SatHi) ? 32'sh7FFFFFFF : (sx < SatLo) ? 32'sh80000000
				: sx[PosW-1:0];
			oy_s2 <= (sy > SatHi) ? 32'sh7FFFFFFF : (sy < SatLo) ? 32'sh80000000
				: sy[PosW-1:0];
			ok_s2 <= pk_s1;
		end
	end

	assign m_tvalid = p_v_s2;
	assign m_tdata  = {6'b0, oy_s2, ox_s2, ok_s2};
	assign m_tlast  = (ok_s2 == CornerLast);

	`ORC_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "output dropped")
	`ORC_ASSERT_IMPL(a_adv, clk, arst_n, hv_q && k_q != CornerLast, !s_tready,
		"head advanced mid item")
	`ORC_ASSERT_NEXT(a_seq, clk, arst_n, p_v_s1 && !p_stall && pk_s1 == CornerLast,
		ok_s2 == CornerLast, "corner order lost")
	`ORC_ASSERT_IMPL(a_idle, clk, arst_n, !hv_q, k_q == '0, "corner count moved while idle")
endmodule
